/* hw/rtl/cdg_pkg.sv */
// Shared constants and codes for the controlled diagonal gate core.
package cdg_pkg;

   // Parameter defaults
   localparam int IndexBitsDefault  = 20;
   localparam int MaxTargetsDefault = 4;
   localparam int SampleBitsDefault = 16;

   // Fixed field and register widths
   localparam int ItemIndexBits = 20;
   localparam int CountBits     = 3;
   localparam int RegBits       = 20;
   localparam int PosBits       = 5;
   localparam int PosSlots      = RegBits / PosBits;
   localparam int CsrIndexBits  = 2;

   // Configuration register indexes
   localparam logic [CsrIndexBits-1:0] CsrTargetCount     = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrTargetPositions = 2'd1;
   localparam logic [CsrIndexBits-1:0] CsrControlSelect   = 2'd2;
   localparam logic [CsrIndexBits-1:0] CsrControlRequired = 2'd3;

   // Transaction function codes
   localparam logic FuncLoad = 1'b0;
   localparam logic FuncAmp  = 1'b1;

endpackage

/* hw/rtl/controlled_diagonal_gate_apply_core.sv */
// Top level of the controlled diagonal gate core: input register, config, gather, stages.
//
// The core takes one transaction per cycle on the req_ channel and, for every amplitude
// transaction (func = 1), returns one response on the rsp_ channel once it has passed the
// input register, product register and output register in turn; table load transactions
// (func = 0) write the diagonal table as they leave the input register and return
// nothing. Throughput is one transaction per cycle while rsp_ready is high; each stage
// holds its own transaction under backpressure, so the core keeps accepting until all
// three registers are full. The diagonal table is 2^MAX_TARGETS registers with no reset:
// load every entry the gate will use before sending amplitudes. Amplitudes whose control
// bits match control_required at the control_select positions are multiplied by the
// table entry gathered from the target bits (target slot j gives entry bit j); others
// pass through unchanged. Results are Q1.(SAMPLE_BITS-2), rounded to nearest with ties
// upward and saturated. Write the csr_ registers only while the core is idle.
module controlled_diagonal_gate_apply_core #(
   parameter int INDEX_BITS  = cdg_pkg::IndexBitsDefault,
   parameter int MAX_TARGETS = cdg_pkg::MaxTargetsDefault,
   parameter int SAMPLE_BITS = cdg_pkg::SampleBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [cdg_pkg::ItemIndexBits-1:0] req_item_index,
   input  logic signed [SAMPLE_BITS-1:0]     req_value_re,
   input  logic signed [SAMPLE_BITS-1:0]     req_value_im,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cdg_pkg::ItemIndexBits-1:0] rsp_out_index,
   output logic signed [SAMPLE_BITS-1:0]     rsp_out_re,
   output logic signed [SAMPLE_BITS-1:0]     rsp_out_im,
   input  logic                              csr_we,
   input  logic [cdg_pkg::CsrIndexBits-1:0]  csr_index,
   input  logic [cdg_pkg::RegBits-1:0]       csr_wdata
);

   localparam int IdxBits = cdg_pkg::ItemIndexBits;
   localparam int PosBits = cdg_pkg::PosBits;
   localparam logic [cdg_pkg::CountBits-1:0] MaxCount = cdg_pkg::CountBits'(MAX_TARGETS);

   // Configuration registers
   logic [cdg_pkg::CountBits-1:0] target_count_ff;
   logic [cdg_pkg::RegBits-1:0]   target_positions_ff;
   logic [cdg_pkg::RegBits-1:0]   control_select_ff;
   logic [cdg_pkg::RegBits-1:0]   control_required_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_count_ff     <= '0;
         target_positions_ff <= '0;
         control_select_ff   <= '0;
         control_required_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cdg_pkg::CsrTargetCount: begin
               target_count_ff <= csr_wdata[cdg_pkg::CountBits-1:0];
            end
            cdg_pkg::CsrTargetPositions: begin
               target_positions_ff <= csr_wdata;
            end
            cdg_pkg::CsrControlSelect: begin
               control_select_ff <= csr_wdata;
            end
            cdg_pkg::CsrControlRequired: begin
               control_required_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Input register
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_func_ff;
   logic [IdxBits-1:0]            s1_index_ff;
   logic signed [SAMPLE_BITS-1:0] s1_re_ff, s1_im_ff;
   logic                          s1_ready;
   logic                          s2_ready;

   // A load leaves at once; an amplitude waits for the product stage
   assign s1_ready    = !s1_valid_ff || (s1_func_ff == cdg_pkg::FuncLoad) || s2_ready;
   assign req_ready   = s1_ready;
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_func_ff  <= req_func;
         s1_index_ff <= req_item_index;
         s1_re_ff    <= req_value_re;
         s1_im_ff    <= req_value_im;
      end
   end

   // Mask index bits at or above INDEX_BITS
   logic [IdxBits-1:0] index_mask;
   for (genvar i = 0; i < IdxBits; i++) begin : g_mask
      assign index_mask[i] = (i < INDEX_BITS);
   end

   logic [IdxBits-1:0] ctrl_sel;
   logic               ctrl_match;
   assign ctrl_sel   = control_select_ff & index_mask;
   assign ctrl_match = ((s1_index_ff & ctrl_sel) == (control_required_ff & ctrl_sel));

   // Gather the table entry number from the target bits
   logic [cdg_pkg::CountBits-1:0] used_count;
   logic [MAX_TARGETS-1:0]        entry;
   assign used_count = (target_count_ff > MaxCount) ? MaxCount : target_count_ff;

   for (genvar j = 0; j < MAX_TARGETS; j++) begin : g_slot
      if (j < cdg_pkg::PosSlots) begin : g_real
         logic [PosBits-1:0] pos;
         logic               pos_ok;
         assign pos    = target_positions_ff[PosBits*j +: PosBits];
         assign pos_ok = (32'(pos) < INDEX_BITS) && (32'(pos) < IdxBits);
         assign entry[j] = (cdg_pkg::CountBits'(j) < used_count) && pos_ok &&
                           s1_index_ff[pos];
      end else begin : g_none
         assign entry[j] = 1'b0;
      end
   end

   // Table write on a load in range, read for the amplitude in the input register
   logic                          tbl_we;
   logic signed [SAMPLE_BITS-1:0] tbl_re, tbl_im;
   assign tbl_we = s1_valid_ff && (s1_func_ff == cdg_pkg::FuncLoad) &&
                   ((s1_index_ff >> MAX_TARGETS) == '0);

   cdg_table #(
      .MAX_TARGETS (MAX_TARGETS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (s1_index_ff[MAX_TARGETS-1:0]),
      .wr_re   (s1_re_ff),
      .wr_im   (s1_im_ff),
      .rd_addr (entry),
      .rd_re   (tbl_re),
      .rd_im   (tbl_im)
   );

   // Product stage
   logic                            s2_in_valid;
   logic                            s2_valid, s3_ready, s2_match;
   logic [IdxBits-1:0]              s2_index;
   logic signed [SAMPLE_BITS-1:0]   s2_a_re, s2_a_im;
   logic signed [2*SAMPLE_BITS-1:0] p_rr, p_ii, p_ri, p_ir;

   assign s2_in_valid = s1_valid_ff && (s1_func_ff == cdg_pkg::FuncAmp);

   cdg_mult_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_in_valid),
      .in_ready  (s2_ready),
      .in_match  (ctrl_match),
      .in_index  (s1_index_ff),
      .a_re      (s1_re_ff),
      .a_im      (s1_im_ff),
      .b_re      (tbl_re),
      .b_im      (tbl_im),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_match (s2_match),
      .out_index (s2_index),
      .out_a_re  (s2_a_re),
      .out_a_im  (s2_a_im),
      .p_rr      (p_rr),
      .p_ii      (p_ii),
      .p_ri      (p_ri),
      .p_ir      (p_ir)
   );

   // Round, saturate and hold the response
   cdg_round_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_round (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_valid),
      .in_ready      (s3_ready),
      .in_match      (s2_match),
      .in_index      (s2_index),
      .a_re          (s2_a_re),
      .a_im          (s2_a_im),
      .p_rr          (p_rr),
      .p_ii          (p_ii),
      .p_ri          (p_ri),
      .p_ir          (p_ir),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_index (rsp_out_index),
      .rsp_out_re    (rsp_out_re),
      .rsp_out_im    (rsp_out_im)
   );

   // An empty output register never backs up the input
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low while output register is empty");

   // An amplitude leaving the input register lands in the product stage
   a_amp_reaches_mult: assert property (@(posedge clock) disable iff (reset)
      (s2_in_valid && s2_ready) |=> s2_valid)
      else $error("amplitude transaction lost between input and product stage");

   // No response right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A load never starts the product stage
   a_load_not_multiplied: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_func_ff == cdg_pkg::FuncLoad) && !s2_valid) |=> !s2_valid)
      else $error("load transaction entered the product stage");

endmodule

/* hw/rtl/cdg_table.sv */
// Diagonal table storage: one write port, one combinational read port.
module cdg_table #(
   parameter int MAX_TARGETS = cdg_pkg::MaxTargetsDefault,
   parameter int SAMPLE_BITS = cdg_pkg::SampleBitsDefault
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [MAX_TARGETS-1:0]        wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_re,
   input  logic signed [SAMPLE_BITS-1:0] wr_im,
   input  logic [MAX_TARGETS-1:0]        rd_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_re,
   output logic signed [SAMPLE_BITS-1:0] rd_im
);

   localparam int Depth = 1 << MAX_TARGETS;

   logic [2*SAMPLE_BITS-1:0] entry_ff [Depth];

   // Store imaginary part in the high half, real part in the low half
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= {wr_im, wr_re};
      end
   end

   assign rd_re = entry_ff[rd_addr][SAMPLE_BITS-1:0];
   assign rd_im = entry_ff[rd_addr][2*SAMPLE_BITS-1:SAMPLE_BITS];

endmodule

/* hw/rtl/cdg_mult_stage.sv */
// Product stage: four signed partial products of the complex multiply, registered.
module cdg_mult_stage #(
   parameter int SAMPLE_BITS = cdg_pkg::SampleBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              in_match,
   input  logic [cdg_pkg::ItemIndexBits-1:0] in_index,
   input  logic signed [SAMPLE_BITS-1:0]     a_re,
   input  logic signed [SAMPLE_BITS-1:0]     a_im,
   input  logic signed [SAMPLE_BITS-1:0]     b_re,
   input  logic signed [SAMPLE_BITS-1:0]     b_im,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              out_match,
   output logic [cdg_pkg::ItemIndexBits-1:0] out_index,
   output logic signed [SAMPLE_BITS-1:0]     out_a_re,
   output logic signed [SAMPLE_BITS-1:0]     out_a_im,
   output logic signed [2*SAMPLE_BITS-1:0]   p_rr,
   output logic signed [2*SAMPLE_BITS-1:0]   p_ii,
   output logic signed [2*SAMPLE_BITS-1:0]   p_ri,
   output logic signed [2*SAMPLE_BITS-1:0]   p_ir
);

   logic                              valid_ff, valid_in;
   logic                              match_ff;
   logic [cdg_pkg::ItemIndexBits-1:0] index_ff;
   logic signed [SAMPLE_BITS-1:0]     a_re_ff, a_im_ff;
   logic signed [2*SAMPLE_BITS-1:0]   p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic                              load;

   // Advance when empty or when the next stage takes the transaction
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture products and the pass-through amplitude
   always_ff @(posedge clock) begin
      if (load) begin
         match_ff <= in_match;
         index_ff <= in_index;
         a_re_ff  <= a_re;
         a_im_ff  <= a_im;
         p_rr_ff  <= a_re * b_re;
         p_ii_ff  <= a_im * b_im;
         p_ri_ff  <= a_re * b_im;
         p_ir_ff  <= a_im * b_re;
      end
   end

   assign out_valid = valid_ff;
   assign out_match = match_ff;
   assign out_index = index_ff;
   assign out_a_re  = a_re_ff;
   assign out_a_im  = a_im_ff;
   assign p_rr      = p_rr_ff;
   assign p_ii      = p_ii_ff;
   assign p_ri      = p_ri_ff;
   assign p_ir      = p_ir_ff;

endmodule

/* hw/rtl/cdg_round_stage.sv */
// Output stage: combine products, round to nearest, saturate, and hold the response.
module cdg_round_stage #(
   parameter int SAMPLE_BITS = cdg_pkg::SampleBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              in_match,
   input  logic [cdg_pkg::ItemIndexBits-1:0] in_index,
   input  logic signed [SAMPLE_BITS-1:0]     a_re,
   input  logic signed [SAMPLE_BITS-1:0]     a_im,
   input  logic signed [2*SAMPLE_BITS-1:0]   p_rr,
   input  logic signed [2*SAMPLE_BITS-1:0]   p_ii,
   input  logic signed [2*SAMPLE_BITS-1:0]   p_ri,
   input  logic signed [2*SAMPLE_BITS-1:0]   p_ir,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cdg_pkg::ItemIndexBits-1:0] rsp_out_index,
   output logic signed [SAMPLE_BITS-1:0]     rsp_out_re,
   output logic signed [SAMPLE_BITS-1:0]     rsp_out_im
);

   localparam int PBits = 2 * SAMPLE_BITS;
   localparam int WBits = PBits + 2;
   localparam int FracBits = SAMPLE_BITS - 2;
   localparam logic [WBits-1:0] Half =
      {{(WBits-FracBits){1'b0}}, 1'b1, {(FracBits-1){1'b0}}};
   localparam logic [WBits-1:0] MaxV =
      {{(WBits-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [WBits-1:0] MinV =
      {{(WBits-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   // Round (x + y) / 2^FracBits to nearest, ties upward, then clamp
   function automatic logic [SAMPLE_BITS-1:0] round_sat(
      input logic [PBits-1:0] x,
      input logic [PBits-1:0] y
   );
      logic [WBits-1:0] xe, ye, sum, shifted;
      logic [SAMPLE_BITS-1:0] res;
      xe      = {{2{x[PBits-1]}}, x};
      ye      = {{2{y[PBits-1]}}, y};
      sum     = xe + ye + Half;
      shifted = WBits'($signed(sum) >>> FracBits);
      if ($signed(shifted) > $signed(MaxV)) begin
         res = MaxV[SAMPLE_BITS-1:0];
      end else if ($signed(shifted) < $signed(MinV)) begin
         res = MinV[SAMPLE_BITS-1:0];
      end else begin
         res = shifted[SAMPLE_BITS-1:0];
      end
      return res;
   endfunction

   logic                              valid_ff, valid_in;
   logic [cdg_pkg::ItemIndexBits-1:0] index_ff;
   logic signed [SAMPLE_BITS-1:0]     re_ff, im_ff;
   logic signed [SAMPLE_BITS-1:0]     re_in, im_in;
   logic [PBits-1:0]                  neg_ii;
   logic                              load;

   assign in_ready = !valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign neg_ii   = PBits'(-p_ii);

   // Apply the gate entry, or pass the amplitude through when controls miss
   always_comb begin
      if (in_match) begin
         re_in = $signed(round_sat(p_rr, neg_ii));
         im_in = $signed(round_sat(p_ri, p_ir));
      end else begin
         re_in = a_re;
         im_in = a_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= in_index;
         re_ff    <= re_in;
         im_ff    <= im_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_index = index_ff;
   assign rsp_out_re    = re_ff;
   assign rsp_out_im    = im_ff;

endmodule

/* verif/cdg_response_checker.sv */
// Response checker for the controlled diagonal gate core: predicts and compares amplitudes.
module cdg_response_checker (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   input  logic                                          req_ready,
   input  logic                                          req_func,
   input  logic [cdg_pkg::ItemIndexBits-1:0]             req_item_index,
   input  logic signed [cdg_pkg::SampleBitsDefault-1:0]  req_value_re,
   input  logic signed [cdg_pkg::SampleBitsDefault-1:0]  req_value_im,
   input  logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   input  logic [cdg_pkg::ItemIndexBits-1:0]             rsp_out_index,
   input  logic signed [cdg_pkg::SampleBitsDefault-1:0]  rsp_out_re,
   input  logic signed [cdg_pkg::SampleBitsDefault-1:0]  rsp_out_im,
   input  logic                                          csr_we,
   input  logic [cdg_pkg::CsrIndexBits-1:0]              csr_index,
   input  logic [cdg_pkg::RegBits-1:0]                   csr_wdata,
   output int                                            mismatch_count,
   output int                                            pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import cdg_pkg::*;

   localparam int     IndexBits  = IndexBitsDefault;
   localparam int     MaxTargets = MaxTargetsDefault;
   localparam int     SampleBits = SampleBitsDefault;
   localparam int     FracBits   = SampleBits - 2;
   localparam int     TableDepth = 1 << MaxTargets;
   localparam longint HalfLsb    = longint'(1) << (FracBits - 1);
   localparam longint SampleMax  = (longint'(1) << (SampleBits - 1)) - 1;
   localparam longint SampleMin  = -SampleMax - 1;
   localparam int     ReportMax  = 10;

   typedef struct packed {
      logic [ItemIndexBits-1:0]    index;
      logic signed [SampleBits-1:0] re;
      logic signed [SampleBits-1:0] im;
   } amplitude_type;

   // Gate settings as last written over the csr port
   logic [CountBits-1:0] gate_count;
   logic [RegBits-1:0]   gate_positions;
   logic [RegBits-1:0]   gate_select;
   logic [RegBits-1:0]   gate_required;

   // Diagonal entries as loaded so far
   logic signed [SampleBits-1:0] diag_re [TableDepth];
   logic signed [SampleBits-1:0] diag_im [TableDepth];

   amplitude_type expected_amps [$];

   // Round to nearest with ties upward, then clamp to the sample range
   function automatic logic signed [SampleBits-1:0] round_sat(longint prod);
      longint q;
      q = (prod + HalfLsb) >>> FracBits;
      if (q > SampleMax) q = SampleMax;
      else if (q < SampleMin) q = SampleMin;
      return SampleBits'(q);
   endfunction

   // Expected output of one amplitude transaction under the current gate
   function automatic amplitude_type apply_gate(logic [ItemIndexBits-1:0] basis,
                                                logic signed [SampleBits-1:0] re,
                                                logic signed [SampleBits-1:0] im);
      amplitude_type         amp;
      logic [MaxTargets-1:0] entry;
      logic [PosBits-1:0]    pos;
      int               slots;
      longint           ar, ai, br, bi;
      amp.index = basis;
      amp.re    = re;
      amp.im    = im;
      entry     = '0;
      if ((basis & gate_select) != (gate_required & gate_select)) return amp;
      slots = (gate_count > MaxTargets) ? MaxTargets : int'(gate_count);
      // Gather the entry number from the target bits; bad positions read zero
      for (int j = 0; j < slots && j < PosSlots; j++) begin
         pos = gate_positions[PosBits*j +: PosBits];
         if (pos < IndexBits) entry[j] = basis[pos];
      end
      ar = re;
      ai = im;
      br = diag_re[entry];
      bi = diag_im[entry];
      amp.re = round_sat(ar * br - ai * bi);
      amp.im = round_sat(ar * bi + ai * br);
      return amp;
   endfunction

   always @(posedge clock) begin : monitor
      amplitude_type seen, want;
      if (reset) begin
         gate_count     = '0;
         gate_positions = '0;
         gate_select    = '0;
         gate_required  = '0;
         mismatch_count = 0;
         expected_amps.delete();
      end else begin
         // Track register writes
         if (csr_we) begin
            case (csr_index)
               CsrTargetCount:     gate_count     = CountBits'(csr_wdata);
               CsrTargetPositions: gate_positions = csr_wdata;
               CsrControlSelect:   gate_select    = csr_wdata;
               CsrControlRequired: gate_required  = csr_wdata;
               default: ;
            endcase
         end
         // Update the table or predict the amplitude for an accepted request
         if (req_valid && req_ready) begin
            if (req_func == FuncLoad) begin
               if (req_item_index < TableDepth) begin
                  diag_re[req_item_index[MaxTargets-1:0]] = req_value_re;
                  diag_im[req_item_index[MaxTargets-1:0]] = req_value_im;
               end
            end else begin
               expected_amps.push_back(apply_gate(req_item_index, req_value_re,
                                                  req_value_im));
            end
         end
         // Compare an accepted response with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_out_index, rsp_out_re, rsp_out_im};
            if (expected_amps.size() == 0) begin
               if (mismatch_count < ReportMax)
                  $display("%0t: unexpected response index %05h re %0d im %0d",
                           $realtime, seen.index, seen.re, seen.im);
               mismatch_count++;
            end else begin
               want = expected_amps.pop_front();
               if (seen.index !== want.index || seen.re !== want.re ||
                   seen.im !== want.im) begin
                  if (mismatch_count < ReportMax)
                     $display("%0t: response mismatch: index %05h/%05h re %0d/%0d im %0d/%0d",
                              $realtime, want.index, seen.index, want.re, seen.re,
                              want.im, seen.im);
                  mismatch_count++;
               end
            end
         end
      end
      pending_results = expected_amps.size();
   end

endmodule

/* verif/controlled_diagonal_gate_apply_core_test.sv */
// Testbench top for the controlled diagonal gate core: stimulus, flow control and verdict.
module controlled_diagonal_gate_apply_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cdg_pkg::*;

   localparam int SampleBits   = SampleBitsDefault;
   localparam int TableDepth   = 1 << MaxTargetsDefault;
   localparam int StallLimit   = 2000;
   localparam int DrainCycles  = 8;
   localparam int SegmentItems = 72;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_func;
   logic [ItemIndexBits-1:0]      req_item_index;
   logic signed [SampleBits-1:0]  req_value_re;
   logic signed [SampleBits-1:0]  req_value_im;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [ItemIndexBits-1:0]      rsp_out_index;
   logic signed [SampleBits-1:0]  rsp_out_re;
   logic signed [SampleBits-1:0]  rsp_out_im;
   logic                          csr_we;
   logic [CsrIndexBits-1:0]       csr_index;
   logic [RegBits-1:0]            csr_wdata;

   int mismatch_count;
   int pending_results;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Control settings in force, used to steer indexes onto matching controls
   logic [RegBits-1:0] cur_select = '0;
   logic [RegBits-1:0] cur_required = '0;

   always #5ns clock = ~clock;

   controlled_diagonal_gate_apply_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_item_index (req_item_index),
      .req_value_re   (req_value_re),
      .req_value_im   (req_value_im),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_re     (rsp_out_re),
      .rsp_out_im     (rsp_out_im),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   cdg_response_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_item_index  (req_item_index),
      .req_value_re    (req_value_re),
      .req_value_im    (req_value_im),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_index   (rsp_out_index),
      .rsp_out_re      (rsp_out_re),
      .rsp_out_im      (rsp_out_im),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // Stall the response channel at random
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic signed [SampleBits-1:0] random_sample();
      case ($urandom_range(15))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         3:       return '1;
         default: return SampleBits'($urandom);
      endcase
   endfunction

   // Present one request transaction, idling first at random, and hold it until accepted
   task automatic send_item(logic func, logic [ItemIndexBits-1:0] index,
                            logic signed [SampleBits-1:0] re,
                            logic signed [SampleBits-1:0] im);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_item_index <= index;
      req_value_re   <= re;
      req_value_im   <= im;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait for every predicted response, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_put(logic [CsrIndexBits-1:0] index, logic [RegBits-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Program all gate registers once the core is idle
   task automatic load_gate_config(logic [CountBits-1:0] count, logic [RegBits-1:0] positions,
                                   logic [RegBits-1:0] select, logic [RegBits-1:0] required);
      settle();
      csr_put(CsrTargetCount, RegBits'(count));
      csr_put(CsrTargetPositions, positions);
      csr_put(CsrControlSelect, select);
      csr_put(CsrControlRequired, required);
      csr_we       <= 1'b0;
      cur_select   = select;
      cur_required = required;
   endtask

   initial begin
      logic signed [SampleBits-1:0] seed_re [TableDepth];
      logic signed [SampleBits-1:0] seed_im [TableDepth];
      logic [ItemIndexBits-1:0]     index;
      logic signed [SampleBits-1:0] re, im;
      logic [CountBits-1:0]         count;
      logic [RegBits-1:0]           positions, select, required;
      int                           seg;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_func       <= FuncLoad;
      req_item_index <= '0;
      req_value_re   <= '0;
      req_value_im   <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CsrTargetCount;
      csr_wdata      <= '0;
      send_idle_pct  = 11;
      recv_idle_pct  = 50;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole table: extremes, unity, half for rounding ties, -j
      for (int e = 0; e < TableDepth; e++) begin
         seed_re[e] = random_sample();
         seed_im[e] = random_sample();
      end
      seed_re[0] = 16'sh8000; seed_im[0] = 16'sh8000;
      seed_re[1] = 16'sh7FFF; seed_im[1] = 16'sh7FFF;
      seed_re[2] = '0;        seed_im[2] = 16'sh7FFF;
      seed_re[3] = 16'sh4000; seed_im[3] = '0;
      seed_re[4] = 16'sh8000; seed_im[4] = 16'sh7FFF;
      seed_re[5] = 16'sh2000; seed_im[5] = '0;
      seed_re[6] = '0;        seed_im[6] = -16'sd16384;
      for (int e = 0; e < TableDepth; e++)
         send_item(FuncLoad, ItemIndexBits'(e), seed_re[e], seed_im[e]);

      // Loads past the table end are dropped
      send_item(FuncLoad, ItemIndexBits'(TableDepth), 16'sh7FFF, 16'sh8000);
      send_item(FuncLoad, 20'hFFFFF, 16'sh7FFF, 16'sh8000);

      // Reset settings: no targets, no controls, everything uses entry 0 and each result saturates in one part
      send_item(FuncAmp, 20'h00000, 16'sh8000, 16'sh8000);
      send_item(FuncAmp, 20'hFFFFF, 16'sh7FFF, 16'sh8000);

      // Four low targets under one control on the top index bit
      load_gate_config(3'd4, {5'd3, 5'd2, 5'd1, 5'd0}, 20'h80000, 20'h80000);
      send_item(FuncAmp, 20'h00003, 16'sd100, 16'sd200);
      send_item(FuncAmp, 20'h80005, 16'sd1, -16'sd1);
      send_item(FuncAmp, 20'h80003, 16'sh8000, 16'sh7FFF);
      send_item(FuncAmp, 20'h80001, 16'sh7FFF, 16'sh7FFF);
      send_item(FuncAmp, 20'h8000F, -16'sd1, 16'sd1);

      // Random segments over three flow-control modes
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       begin send_idle_pct = 11; recv_idle_pct = 50; end
            1:       begin send_idle_pct = 50; recv_idle_pct = 11; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         for (int k = 0; k < 3; k++) begin
            seg = mode * 3 + k;
            count = CountBits'($urandom_range(7));
            for (int slot = 0; slot < PosSlots; slot++)
               positions[PosBits*slot +: PosBits] = ($urandom_range(99) < 85) ?
                  PosBits'($urandom_range(19)) : PosBits'($urandom_range(31, 20));
            case ($urandom_range(3))
               0:       select = '0;
               3:       select = '1;
               default: select = RegBits'($urandom & $urandom & $urandom);
            endcase
            required = RegBits'($urandom);
            // Pin some segments to the corner settings
            case (seg)
               0: begin count = '1; positions = '1; select = '1; required = '1; end
               1: begin
                  count = 3'd4; positions = {5'd3, 5'd2, 5'd1, 5'd0};
                  select = 20'h0000F; required = 20'h00005;
               end
               2: begin count = '0; positions = '0; select = '0; required = '0; end
               4: begin
                  count = 3'd4; positions = {5'd16, 5'd17, 5'd18, 5'd19};
                  select = '0; required = '1;
               end
               default: ;
            endcase
            load_gate_config(count, positions, select, required);

            for (int i = 0; i < SegmentItems; i++) begin
               // Hold off once mid-segment until the core has drained
               if (seg == 4 && i == SegmentItems / 2) settle();
               index = ItemIndexBits'($urandom);
               re    = random_sample();
               im    = random_sample();
               if ($urandom_range(99) < 18) begin
                  if ($urandom_range(9) != 0)
                     index = ItemIndexBits'($urandom_range(TableDepth - 1));
                  send_item(FuncLoad, index, re, im);
               end else begin
                  if ($urandom_range(1) == 1)
                     index = (index & ~cur_select) | (cur_required & cur_select);
                  send_item(FuncAmp, index, re, im);
               end
            end
         end
      end

      settle();
      if (mismatch_count == 0 && pending_results == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
